// ----- sv/lzd_pkg.sv -----
// ----------------------------------------------------------------------------
// lzd_pkg
// Shared types and constants of the LZSS window decompressor.
// ----------------------------------------------------------------------------
package lzd_pkg;

    localparam int CFG_W      = 24;
    localparam int CFG_IDX_W  = 1;
    localparam int WIN_DEPTH  = 4096;
    localparam int WIN_AW     = 12;
    localparam int RING_START = 4078;
    localparam int MIN_LEN    = 3;
    localparam int LEN_W      = 5;
    localparam int DIST_W     = WIN_AW + 1;
    localparam int FIDX_W     = 4;

    localparam logic [CFG_IDX_W-1:0] REG_EXPECTED = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CAPACITY = 1'd1;

    typedef enum logic [2:0] {
        PH_FLAG   = 3'b001,
        PH_TOKEN  = 3'b010,
        PH_SECOND = 3'b100
    } t_phase;

    typedef enum logic [4:0] {
        S_IDLE    = 5'b00001,
        S_DECODE  = 5'b00010,
        S_COPY_RD = 5'b00100,
        S_COPY_WR = 5'b01000,
        S_STATUS  = 5'b10000
    } t_state;

    typedef struct packed {
        logic latch_in;
        logic flag_load;
        logic literal;
        logic first_load;
        logic match_setup;
        logic copy_start;
        logic copy_emit;
        logic status_load;
        logic new_stream;
        logic set_finished;
    } t_dp_cmd;

    typedef struct packed {
        logic   in_last;
        logic   finished;
        logic   target_met;
        logic   reach_after;
        t_phase phase;
        logic   flag_lit;
        logic   out_free;
        logic   copy_more;
    } t_dp_sts;

endpackage

// ----- sv/lzss_4k_window_decompressor.sv -----
// ----------------------------------------------------------------------------
// lzss_4k_window_decompressor
// LZSS stream decompressor, 4096-byte window, match lengths 3 to 18.
// ----------------------------------------------------------------------------
// Flow: a literal is latched from the input, then loaded into the output
//   register in the decode state once it is free; a match is set up and its
//   first byte read from the history RAM, then bytes go out one per cycle while
//   the output is free, with one history RAM read and write each. Input is taken
//   only when idle: no byte is accepted during a decode, copy or status result.
// Reset: synchronous, active low; clears control and counters, config to 1.
//   History RAM is not cleared: copies only read bytes written in this stream.
module lzss_4k_window_decompressor
    import lzd_pkg::*;
#(
    parameter int COUNT_WIDTH = 24
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     s_axis_tvalid,
    output logic                     s_axis_tready,
    input  logic [7:0]               s_axis_tdata,  // in_byte
    input  logic                     s_axis_tlast,
    output logic                     m_axis_tvalid,
    input  logic                     m_axis_tready,
    // data_byte, success, produced_count, consumed_count, zero fill
    output logic [((2*COUNT_WIDTH+10+7)/8)*8-1:0] m_axis_tdata,
    output logic                     m_axis_tuser,  // is_status
    output logic                     m_axis_tlast,
    input  logic                     i_cfg_we,
    input  logic [CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [CFG_W-1:0]         i_cfg_data
);

    localparam int TDATA_W = ((2 * COUNT_WIDTH + 10 + 7) / 8) * 8;

    t_dp_cmd w_cmd;
    t_dp_sts w_sts;

    lzd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    lzd_dp #(
        .COUNT_WIDTH (COUNT_WIDTH),
        .TDATA_W     (TDATA_W)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .i_in_byte   (s_axis_tdata),
        .i_in_last   (s_axis_tlast),
        .i_m_ready   (m_axis_tready),
        .o_m_valid   (m_axis_tvalid),
        .o_m_data    (m_axis_tdata),
        .o_m_user    (m_axis_tuser),
        .o_m_last    (m_axis_tlast),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    a_load_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_cmd.literal || w_cmd.copy_emit || w_cmd.status_load) |-> w_sts.out_free)
        else $error("output register overwritten");

    a_one_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.status_load |-> !(w_cmd.literal || w_cmd.copy_emit))
        else $error("status and data loaded together");

    a_stream_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.new_stream |=> (!w_sts.finished && w_sts.phase == PH_FLAG))
        else $error("new stream did not restart token state");

    a_copy_after_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.copy_start |=> !s_axis_tready)
        else $error("input taken during match copy");

endmodule

// ----- sv/lzd_ram.sv -----
// ----------------------------------------------------------------------------
// lzd_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module lzd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- sv/lzd_ctrl.sv -----
// ----------------------------------------------------------------------------
// lzd_ctrl
// Token sequencer: decodes each transfer and steps the copy loop.
// ----------------------------------------------------------------------------
module lzd_ctrl
    import lzd_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.latch_in = 1'b1;
                    n_state        = S_DECODE;
                end
            end
            S_DECODE: begin
                if (i_sts.finished) begin
                    o_cmd.new_stream = i_sts.in_last;
                    n_state          = S_IDLE;
                end else if (i_sts.target_met) begin
                    n_state = S_STATUS;
                end else begin
                    case (i_sts.phase)
                        PH_FLAG: begin
                            o_cmd.flag_load = 1'b1;
                            n_state = i_sts.in_last ? S_STATUS : S_IDLE;
                        end
                        PH_TOKEN: begin
                            if (!i_sts.flag_lit) begin
                                o_cmd.first_load = 1'b1;
                                n_state = i_sts.in_last ? S_STATUS : S_IDLE;
                            end else if (i_sts.out_free) begin
                                o_cmd.literal = 1'b1;
                                n_state = (i_sts.reach_after || i_sts.in_last) ?
                                          S_STATUS : S_IDLE;
                            end
                        end
                        PH_SECOND: begin
                            o_cmd.match_setup = 1'b1;
                            n_state           = S_COPY_RD;
                        end
                        default: begin
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end
            S_COPY_RD: begin
                o_cmd.copy_start = 1'b1;
                n_state          = S_COPY_WR;
            end
            S_COPY_WR: begin
                if (i_sts.out_free) begin
                    o_cmd.copy_emit = 1'b1;
                    if (!i_sts.copy_more) begin
                        n_state = (i_sts.reach_after || i_sts.in_last) ?
                                  S_STATUS : S_IDLE;
                    end
                end
            end
            S_STATUS: begin
                if (i_sts.out_free) begin
                    o_cmd.status_load  = 1'b1;
                    o_cmd.new_stream   = i_sts.in_last;
                    o_cmd.set_finished = !i_sts.in_last;
                    n_state            = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

// ----- sv/lzd_dp.sv -----
// ----------------------------------------------------------------------------
// lzd_dp
// Datapath: config registers, token state, counters, history RAM, output reg.
// ----------------------------------------------------------------------------
module lzd_dp
    import lzd_pkg::*;
#(
    parameter int COUNT_WIDTH = 24,
    parameter int TDATA_W     = 64
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_dp_cmd              i_cmd,
    output t_dp_sts              o_sts,
    input  logic [7:0]           i_in_byte,
    input  logic                 i_in_last,
    input  logic                 i_m_ready,
    output logic                 o_m_valid,
    output logic [TDATA_W-1:0]   o_m_data,
    output logic                 o_m_user,
    output logic                 o_m_last,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data
);

    localparam int CW    = COUNT_WIDTH;
    localparam int CMP_W = (CW + 1 > CFG_W) ? CW + 1 : CFG_W;
    localparam int SUM_W = CW + 2;

    logic [CFG_W-1:0]  r_expected;
    logic [CFG_W-1:0]  r_capacity;
    logic [7:0]        r_in_byte;
    logic              r_in_last;
    logic [7:0]        r_flag_bits;
    logic [FIDX_W-1:0] r_flag_idx;
    t_phase            r_phase;
    logic [7:0]        r_first;
    logic [CW-1:0]     r_out_count;
    logic [CW:0]       r_in_count;
    logic              r_finished;
    logic [DIST_W-1:0] r_dist;
    logic [LEN_W-1:0]  r_len;
    logic              r_zero;
    logic              r_fwd;
    logic [7:0]        r_fwd_data;

    logic              r_out_valid;
    logic [7:0]        r_out_byte;
    logic              r_out_status;
    logic              r_out_ok;
    logic [CW-1:0]     r_out_prod;
    logic [CW:0]       r_out_cons;
    logic              r_out_last;

    logic [CFG_W-1:0]  w_target;
    logic [CMP_W-1:0]  w_target_x;
    logic [CMP_W-1:0]  w_out_x;
    logic              w_target_met;
    logic              w_reach_after;
    logic              w_out_free;
    logic              w_copy_more;
    logic [SUM_W-1:0]  w_dsum;
    logic [DIST_W-1:0] w_dist;
    logic [CW-1:0]     w_rd_cnt;
    logic [WIN_AW-1:0] w_rd_addr;
    logic              w_rd_zero;
    logic              w_rd_en;
    logic [7:0]        w_ram_q;
    logic [7:0]        w_copy_val;
    logic              w_we;
    logic [7:0]        w_wdata;
    logic [FIDX_W-1:0] w_idx_inc;
    logic              w_token_end;
    logic [1:0]        w_in_add;
    logic [CW+1:0]     w_in_sum;
    logic              w_ok;

    assign w_target      = (r_expected < r_capacity) ? r_expected : r_capacity;
    assign w_target_x    = CMP_W'(w_target);
    assign w_out_x       = CMP_W'(r_out_count);
    assign w_target_met  = (w_out_x >= w_target_x);
    assign w_reach_after = ((w_out_x + CMP_W'(1)) >= w_target_x);
    assign w_out_free    = !r_out_valid || i_m_ready;
    assign w_copy_more   = (r_len > LEN_W'(1)) && !w_reach_after;

    // distance back from the output; wrap far sources into the window
    assign w_dsum = SUM_W'(r_out_count) + SUM_W'(RING_START)
                  - SUM_W'({r_in_byte[7:4], r_first});
    assign w_dist = ($signed(w_dsum) > $signed(SUM_W'(WIN_DEPTH - 1))) ?
                    {1'b0, w_dsum[WIN_AW-1:0]} : w_dsum[DIST_W-1:0];

    assign w_rd_cnt  = i_cmd.copy_start ? r_out_count : r_out_count + CW'(1);
    assign w_rd_addr = w_rd_cnt[WIN_AW-1:0] - r_dist[WIN_AW-1:0];
    assign w_rd_zero = ($signed(r_dist) < $signed(DIST_W'(1)))
                    || (CMP_W'(w_rd_cnt) < CMP_W'(r_dist[WIN_AW-1:0]));
    assign w_rd_en   = i_cmd.copy_start || (i_cmd.copy_emit && w_copy_more);

    assign w_copy_val = r_zero ? 8'd0 : (r_fwd ? r_fwd_data : w_ram_q);
    assign w_we       = i_cmd.literal || i_cmd.copy_emit;
    assign w_wdata    = i_cmd.literal ? r_in_byte : w_copy_val;

    assign w_idx_inc   = r_flag_idx + FIDX_W'(1);
    assign w_token_end = i_cmd.literal || (i_cmd.copy_emit && !w_copy_more);

    assign w_in_add = i_cmd.match_setup ? 2'd2 :
                      (i_cmd.flag_load || i_cmd.literal) ? 2'd1 : 2'd0;
    assign w_in_sum = (CW+2)'(r_in_count) + (CW+2)'(w_in_add);

    assign w_ok = (CMP_W'(r_out_count) == CMP_W'(r_expected)) && (r_expected != '0);

    lzd_ram #(
        .WIDTH (8),
        .DEPTH (WIN_DEPTH)
    ) u_hist (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (r_out_count[WIN_AW-1:0]),
        .i_wdata (w_wdata),
        .i_re    (w_rd_en),
        .i_raddr (w_rd_addr),
        .o_rdata (w_ram_q)
    );

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch_in) begin
            r_in_byte <= i_in_byte;
            r_in_last <= i_in_last;
        end
        if (i_cmd.first_load) begin
            r_first <= r_in_byte;
        end
        if (i_cmd.match_setup) begin
            r_dist <= w_dist;
            r_len  <= LEN_W'(MIN_LEN) + LEN_W'(r_in_byte[3:0]);
        end else if (i_cmd.copy_emit) begin
            r_len <= r_len - LEN_W'(1);
        end
        if (w_rd_en) begin
            r_zero     <= w_rd_zero;
            r_fwd      <= i_cmd.copy_emit && (r_dist == DIST_W'(1));
            r_fwd_data <= w_copy_val;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_expected  <= CFG_W'(1);
            r_capacity  <= CFG_W'(1);
            r_flag_bits <= '0;
            r_flag_idx  <= FIDX_W'(8);
            r_phase     <= PH_FLAG;
            r_out_count <= '0;
            r_in_count  <= '0;
            r_finished  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_EXPECTED: r_expected <= i_cfg_data;
                    REG_CAPACITY: r_capacity <= i_cfg_data;
                    default: ;
                endcase
            end
            if (i_cmd.new_stream) begin
                r_in_count <= '0;
            end else if (w_in_sum[CW+1]) begin
                r_in_count <= '1;
            end else begin
                r_in_count <= w_in_sum[CW:0];
            end
            if (w_we) begin
                r_out_count <= r_out_count + CW'(1);
            end
            if (i_cmd.flag_load) begin
                r_flag_bits <= r_in_byte;
                r_flag_idx  <= '0;
                r_phase     <= PH_TOKEN;
            end
            if (i_cmd.first_load) begin
                r_phase <= PH_SECOND;
            end
            if (w_token_end) begin
                r_flag_idx <= w_idx_inc;
                r_phase    <= w_idx_inc[FIDX_W-1] ? PH_FLAG : PH_TOKEN;
            end
            if (i_cmd.set_finished) begin
                r_finished <= 1'b1;
            end
            if (i_cmd.new_stream) begin
                r_flag_bits <= '0;
                r_flag_idx  <= FIDX_W'(8);
                r_phase     <= PH_FLAG;
                r_out_count <= '0;
                r_finished  <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_we || i_cmd.status_load) begin
            r_out_valid <= 1'b1;
        end else if (i_m_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.status_load) begin
            r_out_byte   <= '0;
            r_out_status <= 1'b1;
            r_out_ok     <= w_ok;
            r_out_prod   <= r_out_count;
            r_out_cons   <= r_in_count;
            r_out_last   <= 1'b1;
        end else if (w_we) begin
            r_out_byte   <= w_wdata;
            r_out_status <= 1'b0;
            r_out_ok     <= 1'b0;
            r_out_prod   <= '0;
            r_out_cons   <= '0;
            r_out_last   <= !(i_cmd.copy_emit && w_copy_more)
                         && !(w_reach_after || r_in_last);
        end
    end

    assign o_m_valid = r_out_valid;
    assign o_m_data  = TDATA_W'({r_out_cons, r_out_prod, r_out_ok, r_out_byte});
    assign o_m_user  = r_out_status;
    assign o_m_last  = r_out_last;

    assign o_sts.in_last     = r_in_last;
    assign o_sts.finished    = r_finished;
    assign o_sts.target_met  = w_target_met;
    assign o_sts.reach_after = w_reach_after;
    assign o_sts.phase       = r_phase;
    assign o_sts.flag_lit    = r_flag_bits[r_flag_idx[2:0]];
    assign o_sts.out_free    = w_out_free;
    assign o_sts.copy_more   = w_copy_more;

endmodule
